/* src/block_request_merger_top_defines.svh */
// ----------------------------------------------------------------------------
// Block request merger assertion macros
// Property wrappers used by the top level to check the merger's logic.
// ----------------------------------------------------------------------------
`ifndef BLOCK_REQUEST_MERGER_TOP_DEFINES_SVH
`define BLOCK_REQUEST_MERGER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define BRM_ASSERT_HOLD(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("brm assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define BRM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brm assertion failed");

// The consequent holds in the cycle after the antecedent.
`define BRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brm assertion failed");

`else

`define BRM_ASSERT_HOLD(lbl, clk, rst, cond)
`define BRM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define BRM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* src/brm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger package
// Types, constants and register map shared by the merger's files.
// ----------------------------------------------------------------------------
package brm_pkg;

   // Depth of the request queue the merge count is bounded by.
   localparam int QUEUE_DEPTH = 128;
   localparam int MERGE_LIMIT = (QUEUE_DEPTH - 1 < 127) ? QUEUE_DEPTH - 1 : 127;

   // Result queue between the merge engine and the output stage.
   // The depth must be a power of two of at least two.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] SYNC_MASK    = 8'h01;
   localparam logic [7:0] NOMERGE_MASK = 8'h08;

   localparam logic [2:0] KIND_READ    = 3'd0;
   localparam logic [2:0] KIND_WRITE   = 3'd1;
   localparam logic [2:0] KIND_FLUSH   = 3'd2;
   localparam logic [2:0] KIND_DISCARD = 3'd3;
   localparam logic [2:0] KIND_ERASE   = 3'd4;
   localparam logic [2:0] KIND_SAME    = 3'd5;
   localparam logic [2:0] KIND_ZEROES  = 3'd6;
   // Code seven names no operation; it is carried through but never merges.
   localparam logic [2:0] KIND_UNUSED  = 3'd7;

   // Register map: word-addressed, byte address 4*i.
   localparam int          CSR_ADDR_W           = 3;
   localparam logic [0:0]  CSR_IDX_MERGE_ENABLE = 1'b0;

   typedef struct packed {
      logic [47:0] start_sector;
      logic [15:0] sector_count;
      logic [7:0]  request_flags;
      logic [2:0]  request_kind;
      logic        last_in_queue;
   } req_type;

   typedef struct packed {
      logic [47:0] out_sector;
      logic [31:0] out_count;
      logic [7:0]  out_flags;
      logic [2:0]  out_kind;
      logic [6:0]  merges_done;
      logic        queue_end;
      logic        last_of_item;
   } rec_type;

   // Up to two results pushed by one request, first one goes out first.
   typedef struct packed {
      logic [1:0] num;
      rec_type    first;
      rec_type    second;
   } push_type;

   typedef struct packed {
      logic       held_valid;
      logic [6:0] merge_total;
   } front_stat_type;

   typedef struct packed {
      logic               empty;
      logic               room2;
      logic [Q_LVL_W-1:0] level;
   } queue_stat_type;

endpackage

/* src/brm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger request channel
// Valid/ready channel carrying one block request per beat.
// ----------------------------------------------------------------------------
interface brm_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] start_sector;
   logic [15:0] sector_count;
   logic [7:0]  request_flags;
   logic [2:0]  request_kind;
   logic        last_in_queue;

   modport source (
      output valid, start_sector, sector_count, request_flags, request_kind,
             last_in_queue,
      input  ready
   );

   modport sink (
      input  valid, start_sector, sector_count, request_flags, request_kind,
             last_in_queue,
      output ready
   );
endinterface

/* src/brm_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger result channel
// Valid/ready channel carrying one emitted request per beat.
// ----------------------------------------------------------------------------
interface brm_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] out_sector;
   logic [31:0] out_count;
   logic [7:0]  out_flags;
   logic [2:0]  out_kind;
   logic [6:0]  merges_done;
   logic        queue_end;
   logic        last_of_item;

   modport source (
      output valid, out_sector, out_count, out_flags, out_kind, merges_done,
             queue_end, last_of_item,
      input  ready
   );

   modport sink (
      input  valid, out_sector, out_count, out_flags, out_kind, merges_done,
             queue_end, last_of_item,
      output ready
   );
endinterface

/* src/brm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger front end
// Holds the pending request, classifies each new one and pushes results.
// ----------------------------------------------------------------------------
module brm_front import brm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  req_type        req,
   input  logic           merge_enable,
   output push_type       push,
   output front_stat_type stat
);

   logic        held_valid_ff,  held_valid_in;
   logic [47:0] held_sector_ff, held_sector_in;
   logic [31:0] held_count_ff,  held_count_in;
   logic [7:0]  held_flags_ff,  held_flags_in;
   logic [2:0]  held_kind_ff,   held_kind_in;
   logic [6:0]  merge_total_ff, merge_total_in;

   logic [32:0] sum_count;
   logic [48:0] held_end;
   logic [48:0] new_end;
   logic        mergeable;
   logic        back_hit;
   logic        front_hit;
   logic        do_merge;
   logic [6:0]  next_total;
   logic        emit_held;
   logic        emit_new;
   rec_type     held_rec;
   rec_type     new_rec;

   always_comb begin
      sum_count = {1'b0, held_count_ff} + 33'(req.sector_count);
      // Ends are exact, so an end past the sector range never matches.
      held_end  = {1'b0, held_sector_ff} + 49'(held_count_ff);
      new_end   = {1'b0, req.start_sector} + 49'(req.sector_count);

      mergeable = merge_enable && held_valid_ff &&
                  (held_kind_ff == req.request_kind) &&
                  ((req.request_kind == KIND_READ) || (req.request_kind == KIND_WRITE)) &&
                  ((held_flags_ff & NOMERGE_MASK) == 8'h00) &&
                  ((req.request_flags & NOMERGE_MASK) == 8'h00) &&
                  !sum_count[32];
      back_hit  = mergeable && (held_end == {1'b0, req.start_sector});
      front_hit = mergeable && !back_hit && (new_end == {1'b0, held_sector_ff});
      do_merge  = back_hit || front_hit;

      if (do_merge && (merge_total_ff < 7'(MERGE_LIMIT))) begin
         next_total = merge_total_ff + 7'd1;
      end else begin
         next_total = merge_total_ff;
      end

      if (do_merge) begin
         held_sector_in = front_hit ? req.start_sector : held_sector_ff;
         held_count_in  = sum_count[31:0];
         held_flags_in  = held_flags_ff | (req.request_flags & SYNC_MASK);
         held_kind_in   = held_kind_ff;
      end else begin
         held_sector_in = req.start_sector;
         held_count_in  = 32'(req.sector_count);
         held_flags_in  = req.request_flags;
         held_kind_in   = req.request_kind;
      end

      held_valid_in  = merge_enable && !req.last_in_queue;
      merge_total_in = req.last_in_queue ? 7'd0 : next_total;

      // The old held request leaves whenever it does not absorb the new one;
      // the new (or merged) request leaves when passing through or at queue end.
      emit_held = held_valid_ff && !do_merge;
      emit_new  = !merge_enable || req.last_in_queue;

      held_rec.out_sector   = held_sector_ff;
      held_rec.out_count    = held_count_ff;
      held_rec.out_flags    = held_flags_ff;
      held_rec.out_kind     = held_kind_ff;
      held_rec.merges_done  = merge_total_ff;
      held_rec.queue_end    = 1'b0;
      held_rec.last_of_item = !emit_new;

      new_rec.out_sector    = held_sector_in;
      new_rec.out_count     = held_count_in;
      new_rec.out_flags     = held_flags_in;
      new_rec.out_kind      = held_kind_in;
      new_rec.merges_done   = next_total;
      new_rec.queue_end     = req.last_in_queue;
      new_rec.last_of_item  = 1'b1;

      push.first  = emit_held ? held_rec : new_rec;
      push.second = new_rec;
      if (accept) begin
         push.num = {1'b0, emit_held} + {1'b0, emit_new};
      end else begin
         push.num = 2'd0;
      end

      stat.held_valid  = held_valid_ff;
      stat.merge_total = merge_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         merge_total_ff <= 7'd0;
      end else if (accept) begin
         held_valid_ff  <= held_valid_in;
         merge_total_ff <= merge_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_sector_ff <= held_sector_in;
         held_count_ff  <= held_count_in;
         held_flags_ff  <= held_flags_in;
         held_kind_ff   <= held_kind_in;
      end
   end

endmodule

/* src/brm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger result queue
// Short queue taking up to two results per cycle and giving out one.
// ----------------------------------------------------------------------------
module brm_queue import brm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  push_type       push,
   input  logic           pop,
   output rec_type        head,
   output queue_stat_type stat
);

   rec_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_LVL_W-1:0] level_ff,  level_in;
   logic [Q_PTR_W-1:0] wr_ptr_next;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + Q_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + Q_PTR_W'(push.num);
      rd_ptr_in   = rd_ptr_ff + Q_PTR_W'(pop);
      level_in    = level_ff + Q_LVL_W'(push.num) - Q_LVL_W'(pop);

      head       = mem_ff[rd_ptr_ff];
      stat.empty = (level_ff == '0);
      stat.room2 = (level_ff <= Q_LVL_W'(Q_DEPTH - 2));
      stat.level = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

/* src/brm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger back end
// Output register draining the result queue one beat per cycle while out_ready.
// ----------------------------------------------------------------------------
module brm_back import brm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  rec_type head,
   input  logic    head_valid,
   output logic    pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rec_type out_rec
);

   logic    valid_ff, valid_in;
   rec_type rec_ff;

   always_comb begin
      pop       = head_valid && (!valid_ff || out_ready);
      valid_in  = pop || (valid_ff && !out_ready);
      out_valid = valid_ff;
      out_rec   = rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head;
      end
   end

endmodule

/* src/block_request_merger_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block request merger
// Back and front merging of queued block requests into one held request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   req_ch    in         valid/ready          one block request per beat
//   rsp_ch    out        valid/ready          one emitted request per beat
//   APB       in         psel/penable/pready  merge_enable at byte address 0
//
// The front end takes one request per cycle while the queue has room;
// a request causes zero, one or two result beats, and the output drains
// one beat per cycle while rsp_ch.ready is high, so the sustained rate
// is one request per cycle while each causes at most one beat. A result
// passes first through the result queue and then through the output
// register before it reaches rsp_ch.
// req_ch.ready drops only when the result queue lacks room for two beats.
// Synchronous reset empties the queue, drops the held request, clears the
// merge total and sets merge_enable to one.
//
`include "block_request_merger_top_defines.svh"

module block_request_merger_top import brm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   brm_req_if.sink               req_ch,
   brm_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // Configuration register. Only the word index is decoded; the low two
   // address bits select a byte within the word and are ignored.
   logic merge_enable_ff, merge_enable_in;
   logic csr_write;
   logic [CSR_ADDR_W-3:0] csr_index;

   always_comb begin
      pready          = 1'b1;
      csr_index       = paddr[CSR_ADDR_W-1:2];
      csr_write       = psel && penable && pwrite;
      merge_enable_in = merge_enable_ff;
      if (csr_write && (csr_index == CSR_IDX_MERGE_ENABLE)) begin
         merge_enable_in = pwdata[0];
      end
      if (csr_index == CSR_IDX_MERGE_ENABLE) begin
         prdata = {31'd0, merge_enable_ff};
      end else begin
         prdata = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_enable_ff <= 1'b1;
      end else begin
         merge_enable_ff <= merge_enable_in;
      end
   end

   // Request side: accept whenever the queue can absorb a two-beat result.
   req_type        req;
   logic           req_accept;
   push_type       push;
   front_stat_type front_stat;
   queue_stat_type queue_stat;
   rec_type        head_rec;
   logic           queue_pop;
   rec_type        out_rec;
   logic           out_valid;

   always_comb begin
      req.start_sector  = req_ch.start_sector;
      req.sector_count  = req_ch.sector_count;
      req.request_flags = req_ch.request_flags;
      req.request_kind  = req_ch.request_kind;
      req.last_in_queue = req_ch.last_in_queue;
      req_ch.ready      = queue_stat.room2;
      req_accept        = req_ch.valid && queue_stat.room2;
   end

   brm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req          (req),
      .merge_enable (merge_enable_ff),
      .push         (push),
      .stat         (front_stat)
   );

   brm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (queue_pop),
      .head  (head_rec),
      .stat  (queue_stat)
   );

   brm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_rec),
      .head_valid (!queue_stat.empty),
      .pop        (queue_pop),
      .out_valid  (out_valid),
      .out_ready  (rsp_ch.ready),
      .out_rec    (out_rec)
   );

   always_comb begin
      rsp_ch.valid        = out_valid;
      rsp_ch.out_sector   = out_rec.out_sector;
      rsp_ch.out_count    = out_rec.out_count;
      rsp_ch.out_flags    = out_rec.out_flags;
      rsp_ch.out_kind     = out_rec.out_kind;
      rsp_ch.merges_done  = out_rec.merges_done;
      rsp_ch.queue_end    = out_rec.queue_end;
      rsp_ch.last_of_item = out_rec.last_of_item;
   end

   // The queue never holds more beats than it has entries.
   `BRM_ASSERT_HOLD(a_queue_level, clock, reset, queue_stat.level <= Q_LVL_W'(Q_DEPTH))
   // The merge count stays within its saturation limit.
   `BRM_ASSERT_HOLD(a_merge_limit, clock, reset, front_stat.merge_total <= 7'(MERGE_LIMIT))
   // The end of a queue leaves nothing held and the merge count cleared.
   `BRM_ASSERT_NEXT(a_queue_flush, clock, reset, req_accept && req.last_in_queue, !front_stat.held_valid && (front_stat.merge_total == 7'd0))
   // The final beat of a queue is always the last beat of its request.
   `BRM_ASSERT_IMPLY(a_end_is_last, clock, reset, out_valid && out_rec.queue_end, out_rec.last_of_item)

endmodule
